@@ design/tpf_pkg.sv @@
package tpf_pkg;

  // Lane count and field widths
  localparam int MOTOR_COUNT = 6;
  localparam int PULSE_W     = 12;
  localparam int THRUST_W    = 15;
  localparam int CFG_W       = 6;

  localparam logic [CFG_W-1:0] CCW_MASK_RST = 6'd37;

  // Pulse band limits in microseconds
  localparam logic [PULSE_W-1:0] W_MIN = 12'd1000;
  localparam logic [PULSE_W-1:0] W_MID = 12'd1500;
  localparam logic [PULSE_W-1:0] W_MAX = 12'd2000;

  // Register stages of one lane, output register included
  localparam int NSTG = 7;

  // Datapath widths
  localparam int WS_W = 12;   // in-band width as a signed operand
  localparam int K0_W = 20;
  localparam int K1_W = 32;
  localparam int K2_W = 44;
  localparam int K3_W = 51;
  localparam int A_W  = 34;   // c3 * w + c2
  localparam int B_W  = 46;   // (...) * w + c1
  localparam int F_W  = 58;   // (...) * w + c0 + rounding offset
  localparam int N_W  = 48;   // numerator, bounded for in-band widths
  localparam int NH_W = 28;   // numerator bits kept for the quotient estimate
  localparam int RC_W = 22;
  localparam int E_W  = NH_W + RC_W;
  localparam int RC_SHIFT = 32;
  localparam int Q_W  = E_W - RC_SHIFT;
  localparam int D_W  = 33;
  localparam int R_W  = Q_W + D_W;

  // Numerator is divided by 10^12 / 256 with floor
  localparam logic signed [D_W-1:0]  DIVISOR = 33'sd3906250000;
  // round(2^52 / DIVISOR); paired with a drop of 20 low bits and a shift of 32
  localparam logic signed [RC_W-1:0] RECIP   = 22'sd1152922;

  localparam logic signed [Q_W:0] THRUST_LIMIT = 19'sd10240;

  typedef enum logic [1:0] {
    POLY_FWD_CW  = 2'b00,
    POLY_FWD_CCW = 2'b01,
    POLY_REV_CW  = 2'b10,
    POLY_REV_CCW = 2'b11
  } poly_sel_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] vld;
  } tpf_ctl_t;

  typedef struct packed {
    logic rev;
    logic zero;
  } tpf_tag_t;

  // Cubic coefficient, milli-units
  function automatic logic signed [K0_W-1:0] poly_k0(input poly_sel_t sel);
    case (sel)
      POLY_FWD_CCW: poly_k0 = 20'sd473380;
      default:      poly_k0 = '0;
    endcase
  endfunction

  // Quadratic coefficient, milli-units times 10^3
  function automatic logic signed [K1_W-1:0] poly_k1(input poly_sel_t sel);
    case (sel)
      POLY_FWD_CW:  poly_k1 = 32'sd26810000;
      POLY_FWD_CCW: poly_k1 = -32'sd1730000000;
      POLY_REV_CW:  poly_k1 = 32'sd46358000;
      POLY_REV_CCW: poly_k1 = 32'sd34400000;
      default:      poly_k1 = '0;
    endcase
  endfunction

  // Linear coefficient, milli-units times 10^6
  function automatic logic signed [K2_W-1:0] poly_k2(input poly_sel_t sel);
    case (sel)
      POLY_FWD_CW:  poly_k2 = -44'sd109040000000;
      POLY_FWD_CCW: poly_k2 = 44'sd2017800000000;
      POLY_REV_CW:  poly_k2 = -44'sd122730000000;
      POLY_REV_CCW: poly_k2 = -44'sd77255000000;
      default:      poly_k2 = '0;
    endcase
  endfunction

  // Constant term, milli-units times 10^9, plus the half-divisor rounding offset
  function automatic logic signed [K3_W-1:0] poly_k3(input poly_sel_t sel);
    case (sel)
      POLY_FWD_CW:  poly_k3 = 51'sd102891953125000;
      POLY_FWD_CCW: poly_k3 = -51'sd729248046875000;
      POLY_REV_CW:  poly_k3 = 51'sd79530953125000;
      POLY_REV_CCW: poly_k3 = 51'sd38073953125000;
      default:      poly_k3 = '0;
    endcase
  endfunction

endpackage

@@ design/tpf_if.sv @@
interface tpf_in_if;
  logic                           valid;
  logic                           ready;
  logic [tpf_pkg::PULSE_W-1:0]    pulse0;
  logic [tpf_pkg::PULSE_W-1:0]    pulse1;
  logic [tpf_pkg::PULSE_W-1:0]    pulse2;
  logic [tpf_pkg::PULSE_W-1:0]    pulse3;
  logic [tpf_pkg::PULSE_W-1:0]    pulse4;
  logic [tpf_pkg::PULSE_W-1:0]    pulse5;

  modport source (
    output valid, pulse0, pulse1, pulse2, pulse3, pulse4, pulse5,
    input  ready
  );
  modport sink (
    input  valid, pulse0, pulse1, pulse2, pulse3, pulse4, pulse5,
    output ready
  );
endinterface

interface tpf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust0;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust1;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust2;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust3;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust4;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust5;

  modport source (
    output valid, thrust0, thrust1, thrust2, thrust3, thrust4, thrust5,
    input  ready
  );
  modport sink (
    input  valid, thrust0, thrust1, thrust2, thrust3, thrust4, thrust5,
    output ready
  );
endinterface

@@ design/thruster_pwm_to_force_unit.sv @@
// Thruster PWM to force: six independent lanes turn pulse widths (us) into
// signed thrust in 1/256 N, clamped to +-10240. Widths 1000..1499 use the
// forward polynomial, 1501..2000 the negated reverse one; 1500 and anything
// outside 1000..2000 give zero. ccw_mask bit i (reset 37) picks the CCW
// coefficient set for motor i; write it only while no item is in flight.
// One item is taken per clock unless a stall reaches the input. Each
// lane has seven register stages: three Horner multiply-add stages, then
// three of reciprocal-multiply division by 10^12/256 with a one-step floor
// correction, then the output register. The first stage loads at the input
// accept edge; output valid rises as the item enters the output register.
// A stalled output holds its item; empty stages further up take new items.
module thruster_pwm_to_force_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  tpf_in_if.sink                      in_ch,
  tpf_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [tpf_pkg::CFG_W-1:0]   cfg_wdata
);

  // Spin direction mask
  logic [tpf_pkg::CFG_W-1:0] ccw_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccw_mask_r <= tpf_pkg::CCW_MASK_RST;
    end else if (cfg_we) begin
      ccw_mask_r <= cfg_wdata;
    end
  end

  // Pipeline valid and stall control
  tpf_pkg::tpf_ctl_t ctl;

  tpf_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  // Gather lane inputs and scatter lane outputs
  logic [tpf_pkg::PULSE_W-1:0]         pulse  [tpf_pkg::MOTOR_COUNT];
  logic signed [tpf_pkg::THRUST_W-1:0] thrust [tpf_pkg::MOTOR_COUNT];

  assign pulse[0] = in_ch.pulse0;
  assign pulse[1] = in_ch.pulse1;
  assign pulse[2] = in_ch.pulse2;
  assign pulse[3] = in_ch.pulse3;
  assign pulse[4] = in_ch.pulse4;
  assign pulse[5] = in_ch.pulse5;

  for (genvar g = 0; g < tpf_pkg::MOTOR_COUNT; g++) begin : g_lane
    tpf_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .pulse  (pulse[g]),
      .ccw    (ccw_mask_r[g]),
      .thrust (thrust[g])
    );
  end

  assign out_ch.thrust0 = thrust[0];
  assign out_ch.thrust1 = thrust[1];
  assign out_ch.thrust2 = thrust[2];
  assign out_ch.thrust3 = thrust[3];
  assign out_ch.thrust4 = thrust[4];
  assign out_ch.thrust5 = thrust[5];

`ifndef SYNTH
  // An empty output register never blocks the input
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  // Accept without delivery grows the occupancy by exactly one
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_ch.valid && in_ch.ready && !(out_ch.valid && out_ch.ready))
    |=> ($countones(ctl.vld) == $past($countones(ctl.vld)) + 1))
    else $error("pipeline occupancy lost or duplicated an item");

  // Every delivered thrust lies within the clamp
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (out_ch.thrust0 <= 15'sd10240) && (out_ch.thrust0 >= -15'sd10240) &&
      (out_ch.thrust1 <= 15'sd10240) && (out_ch.thrust1 >= -15'sd10240) &&
      (out_ch.thrust2 <= 15'sd10240) && (out_ch.thrust2 >= -15'sd10240) &&
      (out_ch.thrust3 <= 15'sd10240) && (out_ch.thrust3 >= -15'sd10240) &&
      (out_ch.thrust4 <= 15'sd10240) && (out_ch.thrust4 >= -15'sd10240) &&
      (out_ch.thrust5 <= 15'sd10240) && (out_ch.thrust5 >= -15'sd10240))
    else $error("thrust beyond clamp");
`endif

endmodule

@@ design/tpf_pipe_ctl.sv @@
module tpf_pipe_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tpf_pkg::tpf_ctl_t ctl
);

  logic [tpf_pkg::NSTG-1:0] vld_r;
  logic [tpf_pkg::NSTG-1:0] vld_nxt;
  logic [tpf_pkg::NSTG-1:0] rdy;

  // A stage takes new data when it is empty or its successor moves on
  always_comb begin
    rdy[tpf_pkg::NSTG-1] = !vld_r[tpf_pkg::NSTG-1] || out_ready;
    for (int i = tpf_pkg::NSTG-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  // Advance valid bits along with the data
  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < tpf_pkg::NSTG; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[tpf_pkg::NSTG-1];
  assign ctl.load  = rdy;
  assign ctl.vld   = vld_r;

endmodule

@@ design/tpf_lane.sv @@
module tpf_lane (
  input  logic                                clk,
  input  tpf_pkg::tpf_ctl_t                   ctl,
  input  logic [tpf_pkg::PULSE_W-1:0]         pulse,
  input  logic                                ccw,
  output logic signed [tpf_pkg::THRUST_W-1:0] thrust
);

  // Stage 1: band decode, coefficient select, c3 * w + c2
  logic                              fwd;
  logic                              rev;
  tpf_pkg::poly_sel_t                sel;
  logic signed [tpf_pkg::WS_W-1:0]   w_s;
  logic signed [tpf_pkg::K1_W-1:0]   m0;
  logic signed [tpf_pkg::A_W-1:0]    a_nxt;

  logic signed [tpf_pkg::A_W-1:0]    a_r;
  logic signed [tpf_pkg::WS_W-1:0]   w1_r;
  tpf_pkg::poly_sel_t                sel1_r;
  tpf_pkg::tpf_tag_t                 tag1_r;

  assign fwd = (pulse >= tpf_pkg::W_MIN) && (pulse < tpf_pkg::W_MID);
  assign rev = (pulse > tpf_pkg::W_MID) && (pulse <= tpf_pkg::W_MAX);
  assign sel = rev ? (ccw ? tpf_pkg::POLY_REV_CCW : tpf_pkg::POLY_REV_CW)
                   : (ccw ? tpf_pkg::POLY_FWD_CCW : tpf_pkg::POLY_FWD_CW);
  // In-band widths fit in 11 bits; out-of-band results are forced to zero later
  assign w_s   = $signed({1'b0, pulse[tpf_pkg::WS_W-2:0]});
  assign m0    = tpf_pkg::poly_k0(sel) * w_s;
  assign a_nxt = tpf_pkg::A_W'(m0) + tpf_pkg::A_W'(tpf_pkg::poly_k1(sel));

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      a_r         <= a_nxt;
      w1_r        <= w_s;
      sel1_r      <= sel;
      tag1_r.rev  <= rev;
      tag1_r.zero <= !(fwd || rev);
    end
  end

  // Stage 2: a * w + c1
  logic signed [tpf_pkg::B_W-1:0]    m1;
  logic signed [tpf_pkg::B_W-1:0]    b_nxt;
  logic signed [tpf_pkg::B_W-1:0]    b_r;
  logic signed [tpf_pkg::WS_W-1:0]   w2_r;
  tpf_pkg::poly_sel_t                sel2_r;
  tpf_pkg::tpf_tag_t                 tag2_r;

  assign m1    = a_r * w1_r;
  assign b_nxt = m1 + tpf_pkg::B_W'(tpf_pkg::poly_k2(sel1_r));

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      b_r    <= b_nxt;
      w2_r   <= w1_r;
      sel2_r <= sel1_r;
      tag2_r <= tag1_r;
    end
  end

  // Stage 3: b * w + c0 + rounding offset gives the numerator
  logic signed [tpf_pkg::F_W-1:0]    m2;
  logic signed [tpf_pkg::F_W-1:0]    f_nxt;
  logic signed [tpf_pkg::N_W-1:0]    n3_r;
  tpf_pkg::tpf_tag_t                 tag3_r;

  assign m2    = b_r * w2_r;
  assign f_nxt = m2 + tpf_pkg::F_W'(tpf_pkg::poly_k3(sel2_r));

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      n3_r   <= $signed(f_nxt[tpf_pkg::N_W-1:0]);
      tag3_r <= tag2_r;
    end
  end

  // Stage 4: quotient estimate from the upper numerator bits and a reciprocal
  logic signed [tpf_pkg::E_W-1:0]    m3;
  logic signed [tpf_pkg::Q_W-1:0]    qe4_r;
  logic signed [tpf_pkg::N_W-1:0]    n4_r;
  tpf_pkg::tpf_tag_t                 tag4_r;

  assign m3 = $signed(n3_r[tpf_pkg::N_W-1:tpf_pkg::N_W-tpf_pkg::NH_W]) * tpf_pkg::RECIP;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      qe4_r  <= $signed(m3[tpf_pkg::E_W-1:tpf_pkg::RC_SHIFT]);
      n4_r   <= n3_r;
      tag4_r <= tag3_r;
    end
  end

  // Stage 5: multiply the estimate back by the divisor
  logic signed [tpf_pkg::R_W-1:0]    p_nxt;
  logic signed [tpf_pkg::R_W-1:0]    p5_r;
  logic signed [tpf_pkg::Q_W-1:0]    qe5_r;
  logic signed [tpf_pkg::N_W-1:0]    n5_r;
  tpf_pkg::tpf_tag_t                 tag5_r;

  assign p_nxt = qe4_r * tpf_pkg::DIVISOR;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      p5_r   <= p_nxt;
      qe5_r  <= qe4_r;
      n5_r   <= n4_r;
      tag5_r <= tag4_r;
    end
  end

  // Stage 6: correct the estimate by one step either way to get the floor
  logic signed [tpf_pkg::R_W-1:0]    rem;
  logic                              q_dec;
  logic                              q_inc;
  logic signed [tpf_pkg::Q_W-1:0]    q_nxt;
  logic signed [tpf_pkg::Q_W-1:0]    q6_r;
  tpf_pkg::tpf_tag_t                 tag6_r;

  assign rem   = tpf_pkg::R_W'(n5_r) - p5_r;
  assign q_dec = rem[tpf_pkg::R_W-1];
  assign q_inc = !q_dec && (rem >= tpf_pkg::R_W'(tpf_pkg::DIVISOR));

  always_comb begin
    q_nxt = qe5_r;
    if (q_inc) begin
      q_nxt = qe5_r + tpf_pkg::Q_W'(1);
    end else if (q_dec) begin
      q_nxt = qe5_r - tpf_pkg::Q_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      q6_r   <= q_nxt;
      tag6_r <= tag5_r;
    end
  end

  // Stage 7: negate reverse thrust, clamp, drop out-of-band and neutral widths
  logic signed [tpf_pkg::Q_W:0]      q_ext;
  logic signed [tpf_pkg::Q_W:0]      q_sgn;
  logic signed [tpf_pkg::Q_W:0]      q_sat;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust_nxt;
  logic signed [tpf_pkg::THRUST_W-1:0] thrust_r;

  // Sign-extend one bit so negation cannot overflow
  assign q_ext = $signed({q6_r[tpf_pkg::Q_W-1], q6_r});

  always_comb begin
    q_sgn = tag6_r.rev ? -q_ext : q_ext;
    if (q_sgn > tpf_pkg::THRUST_LIMIT) begin
      q_sat = tpf_pkg::THRUST_LIMIT;
    end else if (q_sgn < -tpf_pkg::THRUST_LIMIT) begin
      q_sat = -tpf_pkg::THRUST_LIMIT;
    end else begin
      q_sat = q_sgn;
    end
    thrust_nxt = tag6_r.zero ? '0 : $signed(q_sat[tpf_pkg::THRUST_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      thrust_r <= thrust_nxt;
    end
  end

  assign thrust = thrust_r;

endmodule

@@ tb/sv/thruster_pwm_to_force_checker.sv @@
`timescale 1ns / 1ps

module thruster_pwm_to_force_checker
  import tpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tpf_in_if                in_ch,
  tpf_out_if               out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               outstanding
);

  typedef logic [MOTOR_COUNT-1:0][PULSE_W-1:0]  pulse_vec_t;
  typedef logic [MOTOR_COUNT-1:0][THRUST_W-1:0] thrust_vec_t;

  localparam longint PPM_DEN  = 64'sd1000000000000;
  localparam longint PPM_HALF = 64'sd500000000000;
  localparam longint FORCE_MAX = 64'sd10240;

  logic [CFG_W-1:0] ccw_mask;
  thrust_vec_t      thrust_due_q[$];

  // Thrust of one lane in 1/256 N; coefficients are milli-units, p = width / 1000
  function automatic logic [THRUST_W-1:0] thrust_for_width(
    input logic [PULSE_W-1:0] width,
    input logic               ccw
  );
    longint    w, c3, c2, c1, c0, poly, num, q;
    logic      rev;
    poly_sel_t sel;
    w = longint'(width);
    if (width >= W_MIN && width < W_MID) begin
      rev = 1'b0;
    end else if (width > W_MID && width <= W_MAX) begin
      rev = 1'b1;
    end else begin
      return '0;
    end
    if (rev) sel = ccw ? POLY_REV_CCW : POLY_REV_CW;
    else     sel = ccw ? POLY_FWD_CCW : POLY_FWD_CW;
    case (sel)
      POLY_FWD_CW: begin
        c3 = 0;      c2 = 26810;    c1 = -109040; c0 = 102890;
      end
      POLY_FWD_CCW: begin
        c3 = 473380; c2 = -1730000; c1 = 2017800; c0 = -729250;
      end
      POLY_REV_CW: begin
        c3 = 0;      c2 = 46358;    c1 = -122730; c0 = 79529;
      end
      default: begin
        c3 = 0;      c2 = 34400;    c1 = -77255;  c0 = 38072;
      end
    endcase
    // Polynomial scaled by 10^12, exact in 64 bits
    poly = c3 * w * w * w + c2 * w * w * 1000 + c1 * w * 1000000 + c0 * 1000000000;
    // Round to nearest, ties up: floor((256 * poly + half) / den)
    num = poly * 256 + PPM_HALF;
    q = num / PPM_DEN;
    if ((num % PPM_DEN != 0) && (num < 0)) q = q - 1;
    if (rev) q = -q;
    if (q > FORCE_MAX) q = FORCE_MAX;
    if (q < -FORCE_MAX) q = -FORCE_MAX;
    return q[THRUST_W-1:0];
  endfunction

  // Track the mask, queue predictions on input accept, compare on output accept
  always @(posedge clk) begin
    pulse_vec_t  pulses;
    thrust_vec_t want;
    thrust_vec_t got;
    int          delta;
    int          errs;
    delta = 0;
    errs  = 0;
    if (!rst_n) begin
      ccw_mask    <= CCW_MASK_RST;
      thrust_due_q.delete();
      outstanding <= 0;
      mismatches  <= 0;
    end else begin
      if (cfg_we) ccw_mask <= cfg_wdata;

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        pulses = {in_ch.pulse5, in_ch.pulse4, in_ch.pulse3,
                  in_ch.pulse2, in_ch.pulse1, in_ch.pulse0};
        for (int i = 0; i < MOTOR_COUNT; i++)
          want[i] = thrust_for_width(pulses[i], ccw_mask[i]);
        thrust_due_q.push_back(want);
        delta++;
      end

      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.thrust5, out_ch.thrust4, out_ch.thrust3,
               out_ch.thrust2, out_ch.thrust1, out_ch.thrust0};
        if (thrust_due_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, got);
          errs++;
        end else begin
          want = thrust_due_q.pop_front();
          delta--;
          for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: thrust%0d expected %0d actual %0d", $time, i,
                       $signed(want[i]), $signed(got[i]));
              errs++;
            end
          end
        end
      end

      outstanding <= outstanding + delta;
      mismatches  <= mismatches + errs;
    end
  end

endmodule

@@ tb/sv/thruster_pwm_to_force_unit_test.sv @@
`timescale 1ns / 1ps

module thruster_pwm_to_force_unit_test;
  import tpf_pkg::*;

  typedef logic [MOTOR_COUNT-1:0][PULSE_W-1:0] pulse_vec_t;

  localparam int PHASES        = 6;
  localparam int ITEMS_PER_SET = 217;
  localparam int CYCLE_LIMIT   = 600000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               outstanding;
  int               cycle_count;
  int               burst_left;

  tpf_in_if  in_ch ();
  tpf_out_if out_ch ();

  thruster_pwm_to_force_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  thruster_pwm_to_force_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side: free stretches, short stalls and a few long ones
  initial begin
    int hold;
    int r;
    hold = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(20, 80);
        end else if (r < 20) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end else if (r < 45) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 3);
        end
      end
    end
  end

  // Gap after an item: mostly none or short, a few long, with gapless bursts
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item, hold it until accepted, then idle for a random gap
  task automatic drive_pulses(input pulse_vec_t p);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.pulse0 <= p[0];
    in_ch.pulse1 <= p[1];
    in_ch.pulse2 <= p[2];
    in_ch.pulse3 <= p[3];
    in_ch.pulse4 <= p[4];
    in_ch.pulse5 <= p[5];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gap = next_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pick a width: mostly in band, some at the band edges, the rest anywhere
  function automatic logic [PULSE_W-1:0] pick_width();
    int r;
    int edge_w;
    r = $urandom_range(0, 99);
    if (r < 60) return PULSE_W'($urandom_range(W_MIN, W_MAX));
    if (r < 78) begin
      case ($urandom_range(0, 2))
        0:       edge_w = W_MIN;
        1:       edge_w = W_MID;
        default: edge_w = W_MAX;
      endcase
      return PULSE_W'(edge_w + $urandom_range(0, 4) - 2);
    end
    return PULSE_W'($urandom_range(0, (1 << PULSE_W) - 1));
  endfunction

  // Drain the pipe, then write a new mask
  task automatic set_ccw_mask(input logic [CFG_W-1:0] m);
    // Let the count take in the item accepted at this edge
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [PULSE_W-1:0] sweep[16];
    logic [PULSE_W-1:0] mix[6];
    pulse_vec_t         p;
    logic [CFG_W-1:0]   m;

    burst_left   = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.pulse0 <= '0;
    in_ch.pulse1 <= '0;
    in_ch.pulse2 <= '0;
    in_ch.pulse3 <= '0;
    in_ch.pulse4 <= '0;
    in_ch.pulse5 <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, band edges, neutral, out of band, bit patterns
    sweep = '{12'd0, 12'd4095, 12'd999, 12'd1000, 12'd1001, 12'd1250, 12'd1499,
              12'd1500, 12'd1501, 12'd1750, 12'd1999, 12'd2000, 12'd2001,
              12'd2048, 12'd2730, 12'd1365};
    foreach (sweep[k]) begin
      for (int i = 0; i < MOTOR_COUNT; i++) p[i] = sweep[k];
      drive_pulses(p);
    end
    // Rotate mixed widths so every lane sees every region under the reset mask
    mix = '{12'd1000, 12'd1499, 12'd1501, 12'd2000, 12'd1500, 12'd0};
    for (int rot = 0; rot < MOTOR_COUNT; rot++) begin
      for (int i = 0; i < MOTOR_COUNT; i++) p[i] = mix[(i + rot) % MOTOR_COUNT];
      drive_pulses(p);
    end
    in_ch.valid <= 1'b0;

    // Random items under several masks, the extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       m = '0;
        1:       m = '1;
        default: m = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
      endcase
      set_ccw_mask(m);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        for (int i = 0; i < MOTOR_COUNT; i++) p[i] = pick_width();
        drive_pulses(p);
      end
      in_ch.valid <= 1'b0;
    end

    // Drain and report
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (NSTG + 5) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
